// ----- sv/mcid_pkg.sv -----
// Shared types and constants for the multi-channel input debouncer.
package mcid_pkg;

    localparam int unsigned MAX_LANES = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DELAY_W   = 16;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd2;

    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = 16'd50;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_PRESSING  = 2'd1,
        PH_HELD      = 2'd2,
        PH_RELEASING = 2'd3
    } t_phase;

    typedef struct packed {
        logic trig;
        logic untrig;
        logic held;
    } t_lane_res;

    typedef struct packed {
        logic [MAX_LANES-1:0] held_mask;
        logic [MAX_LANES-1:0] untrig_events;
        logic [MAX_LANES-1:0] trig_events;
    } t_result;

endpackage

// ----- sv/mcid_lane.sv -----
// One debounce channel: phase machine, start time and delay test.
module mcid_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_enable,
    input  logic                          i_active,
    input  logic [mcid_pkg::TIME_W-1:0]   i_now,
    input  logic [mcid_pkg::DELAY_W-1:0]  i_debounce,
    output mcid_pkg::t_lane_res           o_res
);
    import mcid_pkg::*;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   n_start;
    logic [TIME_W-1:0]   elapsed;
    logic                expired;

    assign elapsed = i_now - r_start;
    assign expired = (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, i_debounce});

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        case (r_phase)
            PH_IDLE: begin
                if (i_active) begin
                    n_start = i_now;
                    n_phase = PH_PRESSING;
                end
            end
            PH_PRESSING: begin
                if (!i_active) begin
                    n_phase = PH_IDLE;
                end
                if (expired) begin
                    n_phase = PH_HELD;
                end
            end
            PH_HELD: begin
                if (!i_active) begin
                    n_start = i_now;
                    n_phase = PH_RELEASING;
                end
            end
            PH_RELEASING: begin
                if (expired) begin
                    n_phase = PH_IDLE;
                end
                if (i_active) begin
                    n_start = i_now;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.trig   = i_enable && (r_phase == PH_PRESSING) && expired;
        o_res.untrig = i_enable && (r_phase == PH_RELEASING) && expired;
        o_res.held   = i_enable && ((n_phase == PH_HELD) || (n_phase == PH_RELEASING));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_step && i_enable) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_enable) begin
            r_start <= n_start;
        end
    end

endmodule

// ----- sv/mcid_merge.sv -----
// Gathers the lane results into one result beat, with an output register and a skid stage.
module mcid_merge #(
    parameter int unsigned LANES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mcid_pkg::t_lane_res  i_lanes [LANES],
    output logic                 o_valid,
    input  logic                 i_ready,
    output mcid_pkg::t_result    o_result
);
    import mcid_pkg::*;

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result merged;
    logic    take;

    always_comb begin
        merged = '0;
        for (int i = 0; i < LANES; i++) begin
            merged.trig_events[i]   = i_lanes[i].trig;
            merged.untrig_events[i] = i_lanes[i].untrig;
            merged.held_mask[i]     = i_lanes[i].held;
        end
    end

    assign take     = r_out_valid && i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= merged;
            end
        end else if (i_valid) begin
            r_skid <= merged;
        end
    end

endmodule

// ----- sv/multi_channel_input_debouncer_top.sv -----
// Top level of the multi-channel input debouncer: configuration, lanes and result merge.
// An accepted scan's result beat is registered, via the skid stage if the output stalls.
// One scan per cycle while tready is high; each lane does one 32-bit subtract and compare.
// An output register plus a skid stage keep the input ready while one result waits.
// Reset (synchronous, active low) sets every channel idle, clears both result stages,
// and loads channel_count 0, polarity_mask 0 and debounce_ms 50.
module multi_channel_input_debouncer_top #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: levels[7:0], now_ms[39:8].
    input  logic [39:0]                      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: trig_events[7:0], untrig_events[15:8], held_mask[23:16].
    output logic [23:0]                      m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [mcid_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mcid_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import mcid_pkg::*;

    localparam int unsigned LANES = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;

    logic [COUNT_W-1:0]   r_channel_count;
    logic [MAX_LANES-1:0] r_polarity_mask;
    logic [DELAY_W-1:0]   r_debounce_ms;

    logic [MAX_LANES-1:0] levels;
    logic [TIME_W-1:0]    now_ms;
    logic                 step;
    t_lane_res            lane_res [LANES];
    t_result              result;

    assign levels = s_axis_tdata[7:0];
    assign now_ms = s_axis_tdata[39:8];
    assign step   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= '0;
            r_polarity_mask <= '0;
            r_debounce_ms   <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[COUNT_W-1:0];
                REG_POLARITY_MASK: r_polarity_mask <= i_cfg_data[MAX_LANES-1:0];
                REG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mcid_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (step),
            .i_enable   (r_channel_count > COUNT_W'(g)),
            .i_active   (levels[g] == r_polarity_mask[g]),
            .i_now      (now_ms),
            .i_debounce (r_debounce_ms),
            .o_res      (lane_res[g])
        );
    end

    mcid_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (step),
        .o_ready  (s_axis_tready),
        .i_lanes  (lane_res),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {result.held_mask, result.untrig_events, result.trig_events};

    a_stall_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    a_trig_untrig_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((result.trig_events & result.untrig_events) == '0))
        else $error("channel triggered and released in one scan");

    a_trig_is_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((result.trig_events & ~result.held_mask) == '0))
        else $error("triggered channel not reported held");

    a_untrig_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((result.untrig_events & result.held_mask) == '0))
        else $error("released channel still reported held");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the multi-channel input debouncer top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcid_pkg::*;

    localparam int unsigned LANES = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SEGMENTS = 16;
    localparam int unsigned SCANS_PER_SEGMENT = 81;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    logic [COUNT_W-1:0]   cfg_count;
    logic [MAX_LANES-1:0] cfg_polarity;
    logic [DELAY_W-1:0]   cfg_delay;
    t_phase               lane_phase [LANES];
    logic [TIME_W-1:0]    lane_start [LANES];

    t_result              scan_results_due [$];
    t_result              want;
    t_result              got;
    int unsigned          mismatches;
    int unsigned          cycle_count;
    int unsigned          src_idle_pct;
    int unsigned          snk_stall_pct;

    multi_channel_input_debouncer_top #(
        .CHANNELS(LANES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result predict_scan(input logic [7:0] levels,
                                             input logic [TIME_W-1:0] now);
        t_result           r;
        int unsigned       n_lanes;
        int unsigned       i;
        logic              active;
        logic              expired;
        t_phase            ph;
        r = '0;
        n_lanes = cfg_count;
        if (n_lanes > LANES) begin
            n_lanes = LANES;
        end
        if (n_lanes > MAX_LANES) begin
            n_lanes = MAX_LANES;
        end
        for (i = 0; i < n_lanes; i++) begin
            active  = (levels[i] == cfg_polarity[i]);
            expired = ((now - lane_start[i]) >= {16'd0, cfg_delay});
            ph      = lane_phase[i];
            case (ph)
                PH_IDLE: begin
                    if (active) begin
                        lane_start[i] = now;
                        ph = PH_PRESSING;
                    end
                end
                PH_PRESSING: begin
                    if (!active) begin
                        ph = PH_IDLE;
                    end
                    // A delay that runs out on the release scan still triggers.
                    if (expired) begin
                        r.trig_events[i] = 1'b1;
                        ph = PH_HELD;
                    end
                end
                PH_HELD: begin
                    if (!active) begin
                        lane_start[i] = now;
                        ph = PH_RELEASING;
                    end
                end
                default: begin
                    if (expired) begin
                        r.untrig_events[i] = 1'b1;
                        ph = PH_IDLE;
                    end
                    if (active) begin
                        lane_start[i] = now;
                    end
                end
            endcase
            lane_phase[i] = ph;
            if (ph == PH_HELD || ph == PH_RELEASING) begin
                r.held_mask[i] = 1'b1;
            end
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (scan_results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, got);
                mismatches++;
            end else begin
                want = scan_results_due.pop_front();
                if (got.trig_events !== want.trig_events) begin
                    $display("%0t: trig_events expected %h actual %h",
                             $time, want.trig_events, got.trig_events);
                    mismatches++;
                end
                if (got.untrig_events !== want.untrig_events) begin
                    $display("%0t: untrig_events expected %h actual %h",
                             $time, want.untrig_events, got.untrig_events);
                    mismatches++;
                end
                if (got.held_mask !== want.held_mask) begin
                    $display("%0t: held_mask expected %h actual %h",
                             $time, want.held_mask, got.held_mask);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send_scan(input logic [7:0] levels, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 40'({$urandom, $urandom});
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, levels};
        do @(posedge i_clk); while (!s_axis_tready);
        scan_results_due.push_back(predict_scan(levels, now));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (scan_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            REG_CHANNEL_COUNT: cfg_count = data[COUNT_W-1:0];
            REG_POLARITY_MASK: cfg_polarity = data[MAX_LANES-1:0];
            REG_DEBOUNCE_MS:   cfg_delay = data[DELAY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_scan(8'hFF, 32'd0);
        write_reg(REG_CHANNEL_COUNT, 16'hFFF8);
        write_reg(REG_POLARITY_MASK, 16'hABFF);
    endtask

    task automatic test_press_and_release();
        send_scan(8'h01, 32'd100);
        send_scan(8'h01, 32'd149);
        send_scan(8'h01, 32'd150);
        send_scan(8'h00, 32'd160);
        send_scan(8'h01, 32'd170);
        send_scan(8'h00, 32'd219);
        send_scan(8'h00, 32'd220);
    endtask

    task automatic test_release_at_expiry();
        send_scan(8'h02, 32'd300);
        send_scan(8'h00, 32'd350);
        send_scan(8'h00, 32'd351);
        send_scan(8'h00, 32'd401);
    endtask

    task automatic test_active_low_zero_delay();
        write_reg(REG_POLARITY_MASK, 16'hFF00);
        write_reg(REG_DEBOUNCE_MS, 16'd0);
        send_scan(8'h00, 32'd500);
        send_scan(8'h00, 32'd500);
        send_scan(8'hFF, 32'd501);
        send_scan(8'hFF, 32'd501);
    endtask

    task automatic test_wrap_max_delay();
        write_reg(REG_POLARITY_MASK, 16'h00FF);
        write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
        send_scan(8'hFF, 32'hFFFF_8000);
        send_scan(8'hFF, 32'h0000_7FFE);
        send_scan(8'hFF, 32'h0000_7FFF);
    endtask

    task automatic test_channel_count();
        write_reg(REG_CHANNEL_COUNT, 16'h000F);
        write_reg(REG_CHANNEL_COUNT, 16'h0003);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_scan(8'h00, 32'h5555_AAAA);
        write_reg(REG_CHANNEL_COUNT, 16'h000F);
        send_scan(8'hF0, 32'hAAAA_5555);
    endtask

    task automatic test_random_traffic();
        logic [7:0]        lv;
        logic [TIME_W-1:0] now;
        int unsigned       delay;
        int unsigned       seg;
        int unsigned       k;
        int unsigned       pause_at;
        lv  = 8'($urandom);
        now = $urandom;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
                default: begin src_idle_pct = 35; snk_stall_pct = 35; end
            endcase
            write_reg(REG_CHANNEL_COUNT,
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'd8);
            write_reg(REG_POLARITY_MASK, 16'($urandom));
            case ($urandom_range(9))
                0: delay = 0;
                1: delay = 65535;
                2: delay = $urandom_range(65535);
                default: delay = $urandom_range(1, 12);
            endcase
            write_reg(REG_DEBOUNCE_MS, 16'(delay));
            if ($urandom_range(3) == 0) begin
                now = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * delay + 16));
            end
            pause_at = $urandom_range(10, 70);
            for (k = 0; k < SCANS_PER_SEGMENT; k++) begin
                if (k == pause_at) begin
                    drain_results();
                end
                case ($urandom_range(19))
                    0: now = $urandom;
                    1: ;
                    default: now = now + 32'($urandom_range(0, 2 * delay + 2));
                endcase
                if ($urandom_range(9) == 0) begin
                    lv = 8'($urandom);
                end else begin
                    lv = lv ^ 8'($urandom & $urandom & $urandom);
                end
                send_scan(lv, now);
            end
        end
    endtask

    initial begin
        int unsigned i;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_CHANNEL_COUNT;
        i_cfg_data    = '0;
        mismatches    = 0;
        cycle_count   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        cfg_count     = '0;
        cfg_polarity  = '0;
        cfg_delay     = DEBOUNCE_RESET;
        for (i = 0; i < LANES; i++) begin
            lane_phase[i] = PH_IDLE;
            lane_start[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_press_and_release();
        test_release_at_expiry();
        test_active_low_zero_delay();
        test_wrap_max_delay();
        test_channel_count();
        test_random_traffic();
        drain_results();

        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
